FILE: rtl/core/utf16_to_utf8_transcoder_macros.svh
// Assertion helpers for the transcoder. Each use expands to one labelled
// concurrent assertion, sampled on clk and quiet while rst_n is low.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Same-cycle implication.
`define U2U8_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("transcoder check failed (same cycle)");

// Next-cycle implication.
`define U2U8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("transcoder check failed (next cycle)");

`endif

FILE: rtl/core/u2u8_pkg.sv
`default_nettype none

package u2u8_pkg;

  localparam int unsigned MAX_BYTES = 6;

  localparam logic [15:0] SURR_LEAD_LO  = 16'hD800;
  localparam logic [15:0] SURR_LEAD_HI  = 16'hDBFF;
  localparam logic [15:0] SURR_TRAIL_LO = 16'hDC00;
  localparam logic [15:0] SURR_TRAIL_HI = 16'hDFFF;

  localparam logic [20:0] CP_SUPP_BASE  = 21'h10000;
  localparam logic [20:0] CP_LIMIT_1B   = 21'h00080;
  localparam logic [20:0] CP_LIMIT_2B   = 21'h00800;
  localparam logic [20:0] CP_LIMIT_3B   = 21'h10000;

  localparam logic [7:0] LEAD_2B_MARK   = 8'hC0;
  localparam logic [7:0] LEAD_3B_MARK   = 8'hE0;
  localparam logic [7:0] LEAD_4B_MARK   = 8'hF0;
  localparam logic [7:0] CONT_MARK      = 8'h80;

  // U+FFFD, first byte in slot 0
  localparam logic [2:0][7:0] REPL_BYTES = {8'hBD, 8'hBF, 8'hEF};

  // One code point's worth of bytes, slot 0 first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // Everything one request emits, slot 0 first.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                len;
  } job_t;

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < CP_LIMIT_1B) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp < CP_LIMIT_2B) begin
      e.bytes[0] = LEAD_2B_MARK | {3'b000, cp[10:6]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp < CP_LIMIT_3B) begin
      e.bytes[0] = LEAD_3B_MARK | {4'b0000, cp[15:12]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
      e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = LEAD_4B_MARK | {5'b00000, cp[20:18]};
      e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
      e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
      e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

  function automatic enc_t encode_repl();
    enc_t e;
    e = '0;
    e.bytes[2:0] = REPL_BYTES;
    e.len        = 3'd3;
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/u2u8_front.sv
`default_nettype none

module u2u8_front
  import u2u8_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tlast,   // end_of_text
  output logic             push_valid,
  input  wire logic        push_ready,
  output job_t             push_job,
  output logic             lead_pending
);

  logic       lead_pending_r, lead_pending_nxt;
  logic [9:0] lead_bits_r, lead_bits_nxt;

  logic is_lead, is_trail, pair, prefix, accept;
  enc_t main_enc;
  job_t job;

  always_comb begin
    is_lead  = in_tdata inside {[SURR_LEAD_LO:SURR_LEAD_HI]};
    is_trail = in_tdata inside {[SURR_TRAIL_LO:SURR_TRAIL_HI]};
    pair     = lead_pending_r && is_trail;
    prefix   = lead_pending_r && !is_trail;

    if (pair) begin
      main_enc = encode_cp(CP_SUPP_BASE + {1'b0, lead_bits_r, in_tdata[9:0]});
    end else if (is_lead) begin
      // a lead on the final unit can never be paired
      main_enc = in_tlast ? encode_repl() : '0;
    end else if (is_trail) begin
      main_enc = encode_repl();
    end else begin
      main_enc = encode_cp({5'b00000, in_tdata});
    end

    job = '0;
    if (prefix) begin
      // flush the stale lead first, then the new unit on its own
      job.bytes[2:0] = REPL_BYTES;
      job.bytes[5:3] = main_enc.bytes[2:0];
      job.len        = 3'd3 + main_enc.len;
    end else begin
      job.bytes[3:0] = main_enc.bytes;
      job.len        = main_enc.len;
    end
  end

  assign in_tready  = push_ready;
  assign accept     = in_tvalid && push_ready;
  assign push_valid = in_tvalid && (job.len != 3'd0);
  assign push_job   = job;
  assign lead_pending = lead_pending_r;

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_bits_nxt    = lead_bits_r;
    if (accept) begin
      lead_pending_nxt = is_lead && !in_tlast;
      lead_bits_nxt    = (is_lead && !in_tlast) ? in_tdata[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_bits_r    <= 10'd0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      lead_bits_r    <= lead_bits_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u2u8_queue.sv
`default_nettype none

module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/u2u8_back.sv
`default_nettype none

module u2u8_back
  import u2u8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  wire job_t       pop_job,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] out_byte
  output logic            out_tlast    // run_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [2:0] idx_r, idx_nxt;
  logic       load, last_byte;

  // advance when the output slot is free or being taken this cycle
  assign load      = pop_valid && (!out_valid_r || out_tready);
  assign last_byte = (idx_r == pop_job.len - 3'd1);
  assign pop_ready = load && last_byte;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_byte ? 3'd0 : idx_r + 3'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= pop_job.bytes[idx_r];
      out_last_r <= last_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Feed one UTF-16 code unit per request on the
// in_ stream (tlast marks the final unit of the text); UTF-8 bytes leave one
// per request on the out_ stream, with tlast set on the last byte that an
// input unit causes. A leading surrogate is held and yields nothing until
// the next unit: a trailing surrogate completes it into a 4-byte sequence,
// anything else flushes it as EF BF BD and is then handled on its own. Lone
// surrogates, and a lead on the final unit, become EF BF BD. Rate: the
// output byte register issues at most one byte per cycle, and a unit yields
// 0 to 6 bytes (typically 1 to 4, 4 for a surrogate pair); the front end
// takes one unit per cycle while the job queue (QUEUE_DEPTH entries) has
// room. An input unit passes through the job queue and then the output
// byte register before its first byte appears.
`default_nettype none

`include "utf16_to_utf8_transcoder_macros.svh"

module utf16_to_utf8_transcoder
  import u2u8_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2   // job queue entries, 2 to 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tlast,   // end_of_text
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast   // run_last
);

  // front end to queue
  logic q_push_valid, q_push_ready;
  job_t q_push_job;
  // queue to back end
  logic q_pop_valid, q_pop_ready;
  job_t q_pop_job;
  logic lead_pending;

  // Classify each unit, track the held lead and build the byte job.
  u2u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .push_valid   (q_push_valid),
    .push_ready   (q_push_ready),
    .push_job     (q_push_job),
    .lead_pending (lead_pending)
  );

  // Decouple the two halves so a stalled sink does not stop classification
  // until the queue fills.
  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  // Walk each job one byte per cycle into the output register while the output is free or being taken.
  u2u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Jobs that reach the queue always carry between one and six bytes.
  `U2U8_ASSERT_NOW(a_job_len, q_push_valid, (q_push_job.len != 3'd0) && (q_push_job.len <= 3'd6))
  // The final unit of a text never leaves a lead held.
  `U2U8_ASSERT_NEXT(a_eot_clears_lead, in_tvalid && in_tready && in_tlast, !lead_pending)
  // Retiring a job always loads its last byte into the output register.
  `U2U8_ASSERT_NEXT(a_pop_marks_last, q_pop_valid && q_pop_ready, out_tvalid && out_tlast)

endmodule

`default_nettype wire

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Hard stop, far above the slowest legal run: about 150 units at up to six
  // bytes each, with heavy stalling on both sides and one long hold-off.
  localparam int CYCLE_LIMIT  = 400000;
  // Cycles to wait once nothing is expected; covers the path through the job queue and output register.
  localparam int SETTLE       = 16;
  // Length of the receiver's long hold-off that backs up the job queue.
  localparam int HOLD_CYCLES  = 120;
  localparam int N_DIRECTED   = 25;

  // UTF-16 surrogate ranges and the U+FFFD replacement sequence
  localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
  localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
  localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
  localparam logic [20:0] PLANE1_BASE   = 21'h10000;
  localparam logic [0:2][7:0] U_FFFD    = {8'hEF, 8'hBF, 8'hBD};

  // One directed request. Where is_typed is set, the UTF-8 bytes are written
  // out by hand (slot 0 in the top byte); otherwise they come from the
  // transcoder model below.
  typedef struct packed {
    logic [15:0]      unit;
    logic             eot;
    logic             is_typed;
    logic [2:0]       nbytes;
    logic [0:5][7:0]  seq;
  } stim_row_t;

  // One byte awaited on the out_ stream.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'h0000;   // [15:0] code_unit
  logic        in_tlast   = 1'b0;       // end_of_text
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;               // [7:0] out_byte
  logic        out_tlast;               // run_last

  // Transcoder model state: a held leading surrogate and its low ten bits.
  logic        lead_held  = 1'b0;
  logic [9:0]  lead_low   = '0;

  utf8_byte_t  utf8_due[$];   // bytes still awaited, oldest first
  utf8_byte_t  due_head;

  int          error_count   = 0;
  int          bytes_checked = 0;
  int          units_sent    = 0;
  int          pairs_seen    = 0;
  int          flush6_seen   = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Long hold-off request: toggled by the stimulus, served by the receiver.
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int          hold_left = 0;

  // Directed table: edges of each UTF-8 length class, lone surrogates at
  // both ends of the trailing range, the lowest and highest supplementary
  // code points, a lead on the final unit, and leads broken by each kind of
  // follower (plain unit, another lead, a lead on the final unit, a BMP unit
  // above the surrogates).
  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
    '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
    '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
    '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
    '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
    '{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
    '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00},
    '{16'hDFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00},
    '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
    '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
    '{16'hDFFF, 1'b0, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
    '{16'hD800, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00},
    '{16'hD9AB, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'h0041, 1'b1, 1'b0, 3'd0, 48'h0},
    '{16'hDA00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hDB00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hD800, 1'b1, 1'b0, 3'd0, 48'h0},
    '{16'hDBFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hD812, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hDC34, 1'b1, 1'b0, 3'd0, 48'h0},
    '{16'hD83D, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hDE00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{16'hAAAA, 1'b1, 1'b0, 3'd0, 48'h0}
  };

  utf16_to_utf8_transcoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // UTF-8 encoding of one code point, first byte in slot 0. Returns the
  // byte count.
  function automatic int utf8_encode(input logic [20:0] cp, output logic [0:3][7:0] b);
    b = '0;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      return 3;
    end
    b[0] = {5'b11110, cp[20:18]};
    b[1] = {2'b10, cp[17:12]};
    b[2] = {2'b10, cp[11:6]};
    b[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  // Model of the block: consume one code unit, advance the held-lead state
  // and return the bytes it releases (0 to 6).
  function automatic int transcode_unit(input logic [15:0] cu, input logic eot,
                                        output logic [0:5][7:0] seq);
    logic             is_lead;
    logic             is_trail;
    logic [0:3][7:0]  enc;
    int               len;
    int               n;
    int               i;
    is_lead  = (cu >= HI_SURR_FIRST) && (cu <= HI_SURR_LAST);
    is_trail = (cu >= LO_SURR_FIRST) && (cu <= LO_SURR_LAST);
    seq = '0;
    n   = 0;
    if (lead_held) begin
      lead_held = 1'b0;
      if (is_trail) begin
        // complete the pair into a supplementary code point
        len = utf8_encode(PLANE1_BASE + {1'b0, lead_low, cu[9:0]}, enc);
        for (i = 0; i < len; i++) seq[i] = enc[i];
        lead_low = '0;
        return len;
      end
      // broken pair: flush the lead, then treat the new unit on its own
      lead_low = '0;
      for (i = 0; i < 3; i++) seq[i] = U_FFFD[i];
      n = 3;
    end
    if (is_lead) begin
      if (eot) begin
        for (i = 0; i < 3; i++) seq[n+i] = U_FFFD[i];
        n += 3;
      end else begin
        lead_held = 1'b1;
        lead_low  = cu[9:0];
      end
    end else if (is_trail) begin
      for (i = 0; i < 3; i++) seq[n+i] = U_FFFD[i];
      n += 3;
    end else begin
      len = utf8_encode({5'b00000, cu}, enc);
      for (i = 0; i < len; i++) seq[n+i] = enc[i];
      n += len;
    end
    return n;
  endfunction

  // Offer one code unit and hold it until accepted, then queue the bytes it
  // should produce and idle the input as the current phase asks.
  task automatic send_unit(input logic [15:0] cu, input logic eot, input logic is_typed,
                           input logic [2:0] typed_n, input logic [0:5][7:0] typed_seq);
    logic [0:5][7:0] seq;
    int              n;
    int              i;
    in_tvalid <= 1'b1;
    in_tdata  <= cu;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = transcode_unit(cu, eot, seq);
    if (is_typed) begin
      n   = typed_n;
      seq = typed_seq;
    end
    for (i = 0; i < n; i++) utf8_due.push_back('{seq[i], (i == n - 1)});
    units_sent++;
    if (n == 4) pairs_seen++;
    if (n == 6) flush6_seen++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_plain(input logic [15:0] cu, input logic eot);
    send_unit(cu, eot, 1'b0, 3'd0, '0);
  endtask

  // Drop valid and wait until every awaited byte has been seen.
  task automatic drain_output();
    in_tvalid <= 1'b0;
    while (utf8_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random text: mostly well-formed runs (ASCII, two- and three-byte BMP,
  // surrogate pairs) with some lone surrogates and raw 16-bit noise mixed in.
  task automatic random_text(input int count);
    int          sent;
    int          pick;
    logic [15:0] cu;
    logic        eot;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      eot  = ($urandom_range(9) == 0);
      if (pick < 22) begin
        // well-formed pair; the end mark may only fall on the trail
        send_plain(16'($urandom_range(HI_SURR_LAST, HI_SURR_FIRST)), 1'b0);
        send_plain(16'($urandom_range(LO_SURR_LAST, LO_SURR_FIRST)), eot);
        sent += 2;
      end else begin
        if (pick < 42)
          cu = 16'($urandom_range(16'h007F, 16'h0000));
        else if (pick < 58)
          cu = 16'($urandom_range(16'h07FF, 16'h0080));
        else if (pick < 74)
          cu = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h0800))
                                 : 16'($urandom_range(16'hFFFF, 16'hE000));
        else if (pick < 82)
          cu = 16'($urandom_range(HI_SURR_LAST, HI_SURR_FIRST));   // likely unpaired
        else if (pick < 88)
          cu = 16'($urandom_range(LO_SURR_LAST, LO_SURR_FIRST));   // lone trail
        else
          cu = 16'($urandom);
        send_plain(cu, eot);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls at the phase's rate, or a long hold-off when
  // the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_ack   <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted byte with the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (utf8_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected byte, expected none, got data %02h last %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        due_head = utf8_due.pop_front();
        bytes_checked++;
        if (out_tdata !== due_head.data) begin
          error_count++;
          $display("%0t: out_byte mismatch, expected %02h, got %02h",
                   $time, due_head.data, out_tdata);
        end
        if (out_tlast !== due_head.last) begin
          error_count++;
          $display("%0t: run_last mismatch, expected %0b, got %0b",
                   $time, due_head.last, out_tlast);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d bytes still awaited",
               $time, cycle_count, utf8_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, full rate on both sides
    for (r = 0; r < N_DIRECTED; r++)
      send_unit(directed_rows[r].unit, directed_rows[r].eot, directed_rows[r].is_typed,
                directed_rows[r].nbytes, directed_rows[r].seq);
    drain_output();

    // receiver holds off for a long stretch while units keep coming, so the
    // job queue fills and in_tready drops
    hold_req <= ~hold_req;
    random_text(30);
    drain_output();

    // sender mostly idle
    send_idle_pct = 81;
    random_text(30);
    drain_output();

    // receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct <= 81;
    random_text(30);
    drain_output();

    // light idling on both sides
    send_idle_pct  = 17;
    recv_stall_pct <= 17;
    random_text(35);
    drain_output();

    $display("Sent %0d UTF-16 units (%0d from the directed table); checked %0d UTF-8 bytes.",
             units_sent, N_DIRECTED, bytes_checked);
    $display("Saw %0d units yielding four bytes and %0d six-byte flushes of a broken pair.",
             pairs_seen, flush6_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/u2u8_pkg.sv
rtl/core/u2u8_front.sv
rtl/core/u2u8_queue.sv
rtl/core/u2u8_back.sv
rtl/core/utf16_to_utf8_transcoder.sv
dv/testbench.sv
